/* hw/rtl/sector_mapping_table_with_size_account_macros.svh */
// assertion macros shared by the rtl files
`ifndef SECTOR_MAPPING_TABLE_WITH_SIZE_ACCOUNT_MACROS_SVH
`define SECTOR_MAPPING_TABLE_WITH_SIZE_ACCOUNT_MACROS_SVH

// property checked on every clock edge outside reset
`define SMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition in one cycle implies a condition in the next one
`define SMT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/smt_pkg.sv */
package smt_pkg;

  localparam int unsigned SN_W     = 14;
  localparam int unsigned BLK_W    = 10;
  localparam int unsigned PG_W     = 8;
  localparam int unsigned SLOT_W   = 2;
  localparam int unsigned PHYS_W   = 18;
  localparam int unsigned TOTAL_W  = 20;
  localparam int unsigned RUN_BITS = 32;
  localparam int unsigned PAGES_PER_BLOCK = 256;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    logic              op;
    logic [SN_W-1:0]   log_sector;
    logic [BLK_W-1:0]  phys_block;
    logic [PG_W-1:0]   page_id;
    logic [SLOT_W-1:0] slot;
  } in_pl_t;

  typedef struct packed {
    logic [PHYS_W-1:0]  phys_page;
    logic               found;
    logic [TOTAL_W-1:0] table_size;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic cap;
    logic look;
    logic eval;
    logic push;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
  } sts_t;

endpackage

/* hw/rtl/smt_in_if.sv */
interface smt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [smt_pkg::SN_W-1:0]      log_sector;
  logic [smt_pkg::BLK_W-1:0]     phys_block;
  logic [smt_pkg::PG_W-1:0]      page_id;
  logic [smt_pkg::SLOT_W-1:0]    slot;

  modport source (
    output valid, op, log_sector, phys_block, page_id, slot,
    input  ready
  );
  modport sink (
    input  valid, op, log_sector, phys_block, page_id, slot,
    output ready
  );
endinterface

/* hw/rtl/smt_out_if.sv */
interface smt_out_if;
  logic                          valid;
  logic                          ready;
  logic [smt_pkg::PHYS_W-1:0]    phys_page;
  logic                          found;
  logic [smt_pkg::TOTAL_W-1:0]   table_size;

  modport source (
    output valid, phys_page, found, table_size,
    input  ready
  );
  modport sink (
    input  valid, phys_page, found, table_size,
    output ready
  );
endinterface

/* hw/rtl/smt_ram.sv */
module smt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/smt_size.sv */
module smt_size #(
  parameter int unsigned SECTORS_PER_PAGE = 4,
  parameter int unsigned SZ_W             = 10
) (
  input  logic [SECTORS_PER_PAGE-1:0]                    mark_i,
  input  logic [SECTORS_PER_PAGE-1:0][smt_pkg::PHYS_W-1:0] phys_i,
  output logic [SZ_W-1:0]                                size_o
);

  localparam int unsigned SPP = SECTORS_PER_PAGE;
  localparam logic [SZ_W-1:0] RUN_COST = SZ_W'(smt_pkg::RUN_BITS + SPP);
  localparam logic [SZ_W-1:0] ONE_RUN  = SZ_W'(smt_pkg::RUN_BITS);

  logic [SPP-1:0] starts;
  logic [SZ_W-1:0] sum;

  // a written sector opens a run unless it continues the previous offset's page
  for (genvar k = 0; k < SPP; k++) begin : g_start
    if (k == 0) begin : g_first
      assign starts[k] = 1'b1;
    end else begin : g_rest
      assign starts[k] = !mark_i[k-1] || (phys_i[k] != phys_i[k-1]);
    end
  end

  always_comb begin
    sum = '0;
    for (int unsigned k = 0; k < SPP; k++) begin
      sum = sum + (mark_i[k] ? (starts[k] ? RUN_COST : '0) : SZ_W'(1));
    end
  end

  assign size_o = (sum == RUN_COST) ? ONE_RUN : sum;

endmodule

/* hw/rtl/smt_ctrl.sv */
`include "sector_mapping_table_with_size_account_macros.svh"

module smt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  smt_pkg::sts_t sts_i,
  output smt_pkg::cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_LOOK  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_PUSH  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `SMT_ASSERT_NEXT(a_accept_look, in_valid_i && in_ready_o, cmd_o.look, "accept not followed by lookup")
  `SMT_ASSERT(a_push_free, cmd_o.push |-> out_free, "result pushed over an untaken one")
  `SMT_ASSERT_NEXT(a_push_valid, cmd_o.push, out_valid_q, "pushed result not shown")

endmodule

/* hw/rtl/smt_dp.sv */
`include "sector_mapping_table_with_size_account_macros.svh"

module smt_dp #(
  parameter int unsigned SECTORS_PER_PAGE = 4,
  parameter int unsigned LOGICAL_PAGES    = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smt_pkg::cmd_t   cmd_i,
  output smt_pkg::sts_t   sts_o,
  input  smt_pkg::in_pl_t in_pl_i,
  output smt_pkg::res_t   res_o
);

  localparam int unsigned SPP     = SECTORS_PER_PAGE;
  localparam int unsigned AW      = $clog2(LOGICAL_PAGES);
  localparam int unsigned OW      = $clog2(SPP);
  localparam int unsigned SN_W    = smt_pkg::SN_W;
  localparam int unsigned PHYS_W  = smt_pkg::PHYS_W;
  localparam int unsigned SLOT_W  = smt_pkg::SLOT_W;
  localparam int unsigned TOTAL_W = smt_pkg::TOTAL_W;
  // reciprocal for the split of the sector number, exact for SN_W-bit values
  localparam int unsigned SH      = SN_W + OW;
  localparam int unsigned PW      = SH + SN_W;
  localparam int unsigned RECIP   = ((2 ** SH) + SPP - 1) / SPP;
  localparam int unsigned SZ_W    = $clog2(SPP * (smt_pkg::RUN_BITS + SPP) + 1);

  // captured item
  smt_pkg::op_e            op_q;
  logic [SN_W-1:0]         sn_q;
  logic [smt_pkg::BLK_W-1:0] blk_q;
  logic [smt_pkg::PG_W-1:0]  pg_q;
  logic [SLOT_W-1:0]       slot_q;
  logic [SN_W-1:0]         lpn_q;
  logic [PW-1:0]           lpn_prod;

  // lookup stage
  logic [OW-1:0]           off_q;
  logic [PHYS_W-1:0]       phys_q;
  logic                    rng_q;
  logic [SN_W-1:0]         base_sn;

  // memory rows
  logic [AW-1:0]           addr;
  logic [AW-1:0]           clr_cnt_q;
  logic [SPP-1:0]          mark_rd, mark_wr, mark_wdata;
  logic [SPP-1:0][PHYS_W-1:0] phys_rd, phys_wr;
  logic [SPP-1:0][SLOT_W-1:0] slot_rd, slot_wr;
  logic                    wr_en;
  logic                    mark_we;

  // size account
  logic [SZ_W-1:0]         old_sz, new_sz, old_sz_g;
  logic [TOTAL_W-1:0]      total_q, total_d;
  smt_pkg::res_t           res_q, res_d, out_q;

  assign lpn_prod = PW'(in_pl_i.log_sector) * PW'(RECIP);
  assign base_sn  = SN_W'(32'(lpn_q) * SPP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= smt_pkg::op_e'(in_pl_i.op);
      sn_q   <= in_pl_i.log_sector;
      blk_q  <= in_pl_i.phys_block;
      pg_q   <= in_pl_i.page_id;
      slot_q <= in_pl_i.slot;
      lpn_q  <= lpn_prod[SH +: SN_W];
    end
    if (cmd_i.look) begin
      off_q  <= OW'(sn_q - base_sn);
      phys_q <= PHYS_W'(32'(blk_q) * smt_pkg::PAGES_PER_BLOCK + 32'(pg_q));
      rng_q  <= (32'(lpn_q) < LOGICAL_PAGES);
    end
    if (cmd_i.eval) begin
      res_q <= res_d;
    end
    if (cmd_i.push) begin
      out_q <= res_q;
    end
  end

  // clearing pass over the written marks after reset, and the running size total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      total_q   <= '0;
    end else begin
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.eval) begin
        total_q <= total_d;
      end
    end
  end

  assign sts_o.clr_last = (clr_cnt_q == AW'(LOGICAL_PAGES - 1));

  assign addr       = cmd_i.clr ? clr_cnt_q : AW'(lpn_q);
  assign wr_en      = cmd_i.eval && (op_q == smt_pkg::OP_WRITE) && rng_q;
  assign mark_we    = cmd_i.clr || wr_en;
  assign mark_wdata = cmd_i.clr ? '0 : mark_wr;

  always_comb begin
    mark_wr        = mark_rd;
    phys_wr        = phys_rd;
    slot_wr        = slot_rd;
    mark_wr[off_q] = 1'b1;
    phys_wr[off_q] = phys_q;
    slot_wr[off_q] = slot_q;
  end

  smt_ram #(.WIDTH(SPP), .DEPTH(LOGICAL_PAGES)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .addr_i  (addr),
    .wdata_i (mark_wdata),
    .rdata_o (mark_rd)
  );

  smt_ram #(.WIDTH(SPP * PHYS_W), .DEPTH(LOGICAL_PAGES)) u_phys_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (addr),
    .wdata_i (phys_wr),
    .rdata_o (phys_rd)
  );

  smt_ram #(.WIDTH(SPP * SLOT_W), .DEPTH(LOGICAL_PAGES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .addr_i  (addr),
    .wdata_i (slot_wr),
    .rdata_o (slot_rd)
  );

  smt_size #(.SECTORS_PER_PAGE(SPP), .SZ_W(SZ_W)) u_old_size (
    .mark_i (mark_rd),
    .phys_i (phys_rd),
    .size_o (old_sz)
  );

  smt_size #(.SECTORS_PER_PAGE(SPP), .SZ_W(SZ_W)) u_new_size (
    .mark_i (mark_wr),
    .phys_i (phys_wr),
    .size_o (new_sz)
  );

  // a page with no written sector has contributed nothing so far
  assign old_sz_g = (|mark_rd) ? old_sz : '0;
  assign total_d  = wr_en ? (total_q - TOTAL_W'(old_sz_g) + TOTAL_W'(new_sz)) : total_q;

  always_comb begin
    res_d            = '0;
    res_d.table_size = total_d;
    if (rng_q) begin
      if (op_q == smt_pkg::OP_WRITE) begin
        res_d.found     = 1'b1;
        res_d.phys_page = phys_q;
      end else if (mark_rd[off_q]) begin
        res_d.found     = 1'b1;
        res_d.phys_page = phys_rd[off_q];
      end
    end
  end

  assign res_o = out_q;

  `SMT_ASSERT(a_off_range, cmd_i.eval |-> (32'(off_q) < SPP), "sector offset out of page")
  `SMT_ASSERT_NEXT(a_total_hold, cmd_i.eval && !wr_en, total_q == $past(total_q), "size changed without a write")
  `SMT_ASSERT_NEXT(a_write_found, wr_en, res_q.found && (res_q.phys_page == $past(phys_q)), "write result lost its mapping")

endmodule

/* hw/rtl/sector_mapping_table_with_size_account.sv */
// sector mapping table with a running size account
//
// in_i carries one item per transfer: op selects a write of one sector mapping
// (phys_block, page_id and slot give the physical place) or a read of a sector.
// out_o returns exactly one result per item: the physical page and found flag,
// and the encoded table size in bits after the item.
//
// each item passes through capture with the sector split, lookup (row read
// of the logical page from the mark, page and slot memories), evaluate
// (row update, old and new entry size, total update, write back), and push
// into the output register, the order that the single-port read-modify-write
// of a logical page row sets. the next item is taken only after the push.
//
// after reset the written marks are cleared one logical page row per cycle,
// all LOGICAL_PAGES rows in turn; no input is taken until that pass ends.
// a stalled receiver holds the result in the output register; the next item
// is still taken and worked on, and waits in the push step for the register.
module sector_mapping_table_with_size_account #(
  parameter int unsigned SECTORS_PER_PAGE = 4,
  parameter int unsigned LOGICAL_PAGES    = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  smt_in_if.sink     in_i,
  smt_out_if.source  out_o
);

  smt_pkg::cmd_t   cmd;
  smt_pkg::sts_t   sts;
  smt_pkg::in_pl_t in_pl;
  smt_pkg::res_t   res;
  logic            in_ready;
  logic            out_valid;

  // payload of the incoming transfer
  assign in_pl.op         = in_i.op;
  assign in_pl.log_sector = in_i.log_sector;
  assign in_pl.phys_block = in_i.phys_block;
  assign in_pl.page_id    = in_i.page_id;
  assign in_pl.slot       = in_i.slot;

  // sequencing of the item steps and the output handshake
  smt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // memories, size computation, total and result registers
  smt_dp #(
    .SECTORS_PER_PAGE (SECTORS_PER_PAGE),
    .LOGICAL_PAGES    (LOGICAL_PAGES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .in_pl_i (in_pl),
    .res_o   (res)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.phys_page  = res.phys_page;
  assign out_o.found      = res.found;
  assign out_o.table_size = res.table_size;

endmodule
